/* rtl/core/wbps_pkg.sv */
package wbps_pkg;

	localparam int DATA_W        = 8;
	localparam int PATTERN_BYTES = 32;
	localparam int PATTERN_WORDS = 4;
	localparam int WORD_W        = 64;
	localparam int MASK_W        = 32;
	localparam int LEN_W         = 6;
	localparam int SEEN_W        = 64;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_START     = 3'd6;

	localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

endpackage

/* rtl/core/wbps_in_if.sv */
interface wbps_in_if;
	logic                        valid;
	logic                        ready;
	logic [wbps_pkg::DATA_W-1:0] data_byte;
	logic                        last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/wbps_out_if.sv */
interface wbps_out_if #(
	parameter int ADDRESS_BITS = 64
);
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic [ADDRESS_BITS-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink   (input valid, input found, input match_address, output ready);
endinterface

/* rtl/core/wildcard_byte_pattern_scanner_unit.sv */
// Masked byte pattern search over one memory range. One byte of the range enters per
// item, and a new item is taken in every clock cycle while the result side keeps up.
// A result (found with the match address, or not found on the last byte of the range)
// passes through the s2 result register into the s3 output register; after a match the
// rest of the range is absorbed without results. The per-cycle work is one parallel
// byte compare across the window plus the byte count compare, set by the window
// register loop. Pattern registers feed an aligned copy that is refreshed on the cycle
// after each write, so program the pattern while no range is in flight.
module wildcard_byte_pattern_scanner_unit #(
	parameter int MAX_PATTERN_BYTES = 32,
	parameter int ADDRESS_BITS      = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	wbps_in_if.sink                             src,
	wbps_out_if.source                          dst,
	input  logic                                cfg_we,
	input  logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int MW   = MAX_PATTERN_BYTES;
	localparam int DW   = wbps_pkg::DATA_W;
	localparam int N_W  = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int SW   = wbps_pkg::SEEN_W;
	localparam logic [wbps_pkg::LEN_W:0] MAX_LEN = (wbps_pkg::LEN_W + 1)'(MAX_PATTERN_BYTES);
	localparam logic [N_W-1:0] MAX_N = N_W'(MAX_PATTERN_BYTES);

	// configuration registers
	logic [wbps_pkg::PATTERN_WORDS-1:0][wbps_pkg::WORD_W-1:0] pat_words_q;
	logic [wbps_pkg::MASK_W-1:0]  mask_q;
	logic [wbps_pkg::LEN_W-1:0]   len_q;
	logic [ADDRESS_BITS-1:0]      start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_words_q <= '0;
			mask_q      <= '0;
			len_q       <= wbps_pkg::LEN_RESET;
			start_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wbps_pkg::REG_PATTERN_0: pat_words_q[0] <= cfg_wdata;
				wbps_pkg::REG_PATTERN_1: pat_words_q[1] <= cfg_wdata;
				wbps_pkg::REG_PATTERN_2: pat_words_q[2] <= cfg_wdata;
				wbps_pkg::REG_PATTERN_3: pat_words_q[3] <= cfg_wdata;
				wbps_pkg::REG_WILDCARD:  mask_q  <= cfg_wdata[wbps_pkg::MASK_W-1:0];
				wbps_pkg::REG_LENGTH:    len_q   <= cfg_wdata[wbps_pkg::LEN_W-1:0];
				wbps_pkg::REG_START:     start_q <= cfg_wdata[ADDRESS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// effective length, clamped to the window
	logic [N_W-1:0] n_len;
	assign n_len = ({1'b0, len_q} > MAX_LEN) ? MAX_N : N_W'(len_q);

	// pattern byte-reversed over the window, positions past the register file read as zero
	logic [MW*DW-1:0] rev_pat;
	logic [MW-1:0]    rev_care;

	for (genvar k = 0; k < MW; k++) begin : g_rev
		if (k < wbps_pkg::PATTERN_BYTES) begin : g_cfg
			assign rev_pat[(MW-1-k)*DW +: DW] = pat_words_q[k/8][(k%8)*DW +: DW];
			assign rev_care[MW-1-k]           = !mask_q[k];
		end else begin : g_zero
			assign rev_pat[(MW-1-k)*DW +: DW] = '0;
			assign rev_care[MW-1-k]           = 1'b1;
		end
	end

	// align so that window byte k (newest first) faces pattern byte n-1-k
	logic [N_W-1:0]   align_sh;
	logic [MW*DW-1:0] apat_q;
	logic [MW-1:0]    acare_q;

	assign align_sh = MAX_N - n_len;

	always_ff @(posedge clk) begin
		apat_q  <= rev_pat >> {align_sh, 3'b000};
		acare_q <= rev_care >> align_sh;
	end

	// input register
	logic          valid_s1;
	logic [DW-1:0] data_s1;
	logic          last_s1;
	logic          fire_s1;

	assign src.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			data_s1 <= src.data_byte;
			last_s1 <= src.last_byte;
		end
	end

	// range state
	logic [MW-1:0][DW-1:0] win_q;
	logic [SW-1:0]         seen_q;
	logic                  rep_q;

	logic [MW-1:0][DW-1:0] win_new;
	logic [MW-1:0]         hit;
	logic [SW-1:0]         seen_new;
	logic [SW:0]           diff;
	logic                  match;
	logic                  has_res;

	always_comb begin
		win_new[0] = data_s1;
		for (int k = 1; k < MW; k++) begin
			win_new[k] = win_q[k-1];
		end
		for (int k = 0; k < MW; k++) begin
			hit[k] = !acare_q[k] || (win_new[k] == apat_q[k*DW +: DW]);
		end
	end

	assign seen_new = (&seen_q) ? seen_q : seen_q + SW'(1);
	assign diff     = {1'b0, seen_new} - (SW + 1)'(n_len);
	assign match    = !rep_q && (n_len != '0) && !diff[SW] && (&hit);
	assign has_res  = !rep_q && (match || last_s1);

	// result pipeline
	logic                    valid_s2;
	logic                    found_s2;
	logic [ADDRESS_BITS-1:0] off_s2;
	logic                    valid_s3;
	logic                    found_s3;
	logic [ADDRESS_BITS-1:0] addr_s3;
	logic                    free_s3;
	logic                    free_s2;

	assign free_s3 = !valid_s3 || dst.ready;
	assign free_s2 = !valid_s2 || free_s3;
	assign fire_s1 = valid_s1 && (!has_res || free_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			seen_q <= '0;
			rep_q  <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				win_q  <= '0;
				seen_q <= '0;
				rep_q  <= 1'b0;
			end else if (!rep_q) begin
				win_q  <= win_new;
				seen_q <= seen_new;
				rep_q  <= match;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (free_s2) begin
				valid_s2 <= fire_s1 && has_res;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && fire_s1 && has_res) begin
			found_s2 <= match;
			off_s2   <= diff[ADDRESS_BITS-1:0];
		end
		if (free_s3 && valid_s2) begin
			found_s3 <= found_s2;
			addr_s3  <= found_s2 ? start_q + off_s2 : '0;
		end
	end

	assign dst.valid         = valid_s3;
	assign dst.found         = found_s3;
	assign dst.match_address = addr_s3;

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid && !dst.found |-> dst.match_address == '0)
		else $error("not-found item carries an address");

	a_match_latches: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && match && !last_s1 |=> rep_q)
		else $error("match without hold of the range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> seen_q == '0 && !rep_q)
		else $error("range state kept past last byte");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !free_s3 |=> valid_s2 && $stable(found_s2) && $stable(off_s2))
		else $error("stalled result stage dropped its item");

	a_silent_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rep_q |-> !has_res && fire_s1)
		else $error("result raised after a reported match");

endmodule
